FILE: hw/rtl/sest_pkg.sv
// Shared types and codes for the signature superset edge scan block.
package sest_pkg;

   // Width of the edge index field carried on result words.
   localparam int unsigned IDX_W = 10;

   // Request type codes.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_STORED = 2'd0,
      KIND_FULL   = 2'd1,
      KIND_MATCH  = 2'd2,
      KIND_DONE   = 2'd3
   } sest_kind_type;

   typedef logic [IDX_W-1:0] sest_idx_type;

   // One request word.
   typedef struct packed {
      logic        req_type;
      logic [31:0] gene_first;
      logic [31:0] gene_second;
      logic [63:0] signature;
      logic [5:0]  expected_count;
   } sest_req_type;

   // One result word.
   typedef struct packed {
      logic [1:0]   kind;
      sest_idx_type edge_index;
      logic [31:0]  gene_first_res;
      logic [31:0]  gene_second_res;
      logic [5:0]   match_count;
      logic         count_ok;
      logic         last;
   } sest_rsp_type;

   // Enables from the sequencer to the edge table.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } sest_mem_ctl_type;

endpackage

FILE: hw/rtl/sest_chan_if.sv
// Valid/ready channel interface carrying one payload word per handshake.
interface sest_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/signature_superset_edge_scan_top.sv
// Top level of the signature superset edge scan block.
//
//   Channel  Direction  Payload                 Words per request
//   req_     in         load edge or query      one
//   rsp_     out        stored/full/match/done  one per load, up to 64 per query
//
// A load's result word is registered and offered the next cycle.
// A query scans the stored edges one per cycle, unless the result register is held,
// through the table's single read port, and may stop early.
// req_chan.ready is low while a query runs and while the result register is held.
// A held result stalls the scan in place; nothing is lost or repeated.
// Reset clears the edge count and control state; table contents need no clearing.
module signature_superset_edge_scan_top
   import sest_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH  = 1024,
   parameter int unsigned SIG_BITS     = 64,
   parameter int unsigned MAX_EXPECTED = 63
) (
   input  logic        clock,
   input  logic        reset,
   sest_chan_if.sink   req_chan,
   sest_chan_if.source rsp_chan
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);

   sest_mem_ctl_type    mem_ctl;
   logic [AW-1:0]       wr_addr;
   logic [SIG_BITS-1:0] wr_sig;
   logic [63:0]         wr_genes;
   logic [AW-1:0]       rd_addr;
   logic [SIG_BITS-1:0] rd_sig;
   logic [63:0]         rd_genes;
   logic [SIG_BITS-1:0] pattern;
   logic                hit;
   logic                req_ready;
   logic                res_valid;
   sest_rsp_type        res;

   // Sequencer with the result register.
   sest_seq #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SIG_BITS     (SIG_BITS),
      .MAX_EXPECTED (MAX_EXPECTED)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .req       (req_chan.payload),
      .res_valid (res_valid),
      .res_ready (rsp_chan.ready),
      .res       (res),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_sig    (wr_sig),
      .wr_genes  (wr_genes),
      .rd_addr   (rd_addr),
      .rd_genes  (rd_genes),
      .pattern   (pattern),
      .hit       (hit)
   );

   // Edge table memories.
   sest_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SIG_BITS    (SIG_BITS)
   ) u_table (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_sig   (wr_sig),
      .wr_genes (wr_genes),
      .rd_addr  (rd_addr),
      .rd_sig   (rd_sig),
      .rd_genes (rd_genes)
   );

   // Superset test on the word just read.
   sest_match #(
      .SIG_BITS (SIG_BITS)
   ) u_match (
      .entry_sig (rd_sig),
      .pattern   (pattern),
      .hit       (hit)
   );

   // Channel hookup.
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = res_valid;
   assign rsp_chan.payload = res;

endmodule

FILE: hw/rtl/sest_table.sv
// Edge table: signature and gene pair memories, one write and one registered read port.
module sest_table
   import sest_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned SIG_BITS    = 64,
   localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
   input  logic                  clock,
   input  sest_mem_ctl_type      mem_ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [SIG_BITS-1:0]   wr_sig,
   input  logic [63:0]           wr_genes,
   input  logic [AW-1:0]         rd_addr,
   output logic [SIG_BITS-1:0]   rd_sig,
   output logic [63:0]           rd_genes
);

   logic [SIG_BITS-1:0] sig_mem_ff  [TABLE_DEPTH];
   logic [63:0]         gene_mem_ff [TABLE_DEPTH];
   logic [SIG_BITS-1:0] rd_sig_ff;
   logic [63:0]         rd_genes_ff;

   // Write port: appends an edge at the address given by the sequencer.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         sig_mem_ff[wr_addr]  <= wr_sig;
         gene_mem_ff[wr_addr] <= wr_genes;
      end
   end

   // Read port: data is registered and holds while reads are not enabled.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_sig_ff   <= sig_mem_ff[rd_addr];
         rd_genes_ff <= gene_mem_ff[rd_addr];
      end
   end

   assign rd_sig   = rd_sig_ff;
   assign rd_genes = rd_genes_ff;

endmodule

FILE: hw/rtl/sest_match.sv
// Superset test unit: an edge matches when its signature holds every pattern bit.
module sest_match
   import sest_pkg::*;
#(
   parameter int unsigned SIG_BITS = 64
) (
   input  logic [SIG_BITS-1:0] entry_sig,
   input  logic [SIG_BITS-1:0] pattern,
   output logic                hit
);

   // A pattern bit missing from the entry clears the match.
   assign hit = ((entry_sig & pattern) == pattern);

endmodule

FILE: hw/rtl/sest_seq.sv
// Sequencer: takes load and query words, steps the table scan, and holds the result register.
module sest_seq
   import sest_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH  = 1024,
   parameter int unsigned SIG_BITS     = 64,
   parameter int unsigned MAX_EXPECTED = 63,
   localparam int unsigned AW          = $clog2(TABLE_DEPTH),
   localparam int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sest_req_type        req,
   output logic                res_valid,
   input  logic                res_ready,
   output sest_rsp_type        res,
   output sest_mem_ctl_type    mem_ctl,
   output logic [AW-1:0]       wr_addr,
   output logic [SIG_BITS-1:0] wr_sig,
   output logic [63:0]         wr_genes,
   output logic [AW-1:0]       rd_addr,
   input  logic [63:0]         rd_genes,
   output logic [SIG_BITS-1:0] pattern,
   input  logic                hit
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   state_type           state_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       idx_ff;
   logic [CW-1:0]       tidx_ff;
   logic                tv_ff;
   logic [5:0]          found_ff;
   logic [SIG_BITS-1:0] pat_ff;
   logic [5:0]          exp_ff;
   logic                res_valid_ff;
   sest_rsp_type        res_ff;

   logic       stall;
   logic       full;
   logic       accept;
   logic       hit_now;
   logic [5:0] found_in;
   logic       stop;
   logic       res_load;

   // Assemble one result word; fields that mean nothing for a kind stay zero.
   function automatic sest_rsp_type make_rsp(sest_kind_type kind, sest_idx_type idx,
                                             logic [63:0] genes, logic [5:0] cnt,
                                             logic ok, logic last);
      sest_rsp_type r;
      r.kind            = kind;
      r.edge_index      = idx;
      r.gene_first_res  = genes[31:0];
      r.gene_second_res = genes[63:32];
      r.match_count     = cnt;
      r.count_ok        = ok;
      r.last            = last;
      return r;
   endfunction

   // Handshake and scan decisions.
   assign stall     = res_valid_ff && !res_ready;
   assign req_ready = (state_ff == S_IDLE) && !stall;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(TABLE_DEPTH));
   assign hit_now   = tv_ff && hit;
   assign found_in  = found_ff + {5'd0, hit_now};
   // The scan ends once the expected or maximum count is met, or the table runs out.
   assign stop      = (found_in == exp_ff) || (found_in >= 6'(MAX_EXPECTED))
                      || (idx_ff >= count_ff);

   // A new result word enters the result register in these cycles.
   assign res_load = (accept && (req.req_type == REQ_LOAD))
                     || ((state_ff == S_SCAN) && !stall && hit_now)
                     || ((state_ff == S_DONE) && !stall);

   // Table access.
   assign mem_ctl.wr_en = accept && (req.req_type == REQ_LOAD) && !full;
   assign mem_ctl.rd_en = (state_ff == S_SCAN) && !stall && !stop;
   assign wr_addr       = count_ff[AW-1:0];
   assign wr_sig        = req.signature[SIG_BITS-1:0];
   assign wr_genes      = {req.gene_second, req.gene_first};
   assign rd_addr       = idx_ff[AW-1:0];
   assign pattern       = pat_ff;

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   // State machine, scan counters and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         tv_ff        <= 1'b0;
         found_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         // The result stays valid while held, and refills when a new word is loaded.
         res_valid_ff <= res_load || stall;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req.req_type == REQ_LOAD) begin
                     if (full) begin
                        res_ff <= make_rsp(KIND_FULL, '0, '0, '0, 1'b0, 1'b1);
                     end else begin
                        res_ff   <= make_rsp(KIND_STORED, sest_idx_type'(count_ff),
                                             '0, '0, 1'b0, 1'b1);
                        count_ff <= count_ff + CW'(1);
                     end
                  end else begin
                     pat_ff   <= req.signature[SIG_BITS-1:0];
                     exp_ff   <= req.expected_count;
                     idx_ff   <= '0;
                     found_ff <= '0;
                     tv_ff    <= 1'b0;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (!stall) begin
                  if (hit_now) begin
                     res_ff   <= make_rsp(KIND_MATCH, sest_idx_type'(tidx_ff),
                                          rd_genes, '0, 1'b0, 1'b0);
                     found_ff <= found_in;
                  end
                  if (stop) begin
                     tv_ff    <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     tidx_ff <= idx_ff;
                     tv_ff   <= 1'b1;
                     idx_ff  <= idx_ff + CW'(1);
                  end
               end
            end
            S_DONE: begin
               if (!stall) begin
                  res_ff   <= make_rsp(KIND_DONE, '0, '0, found_ff,
                                       found_ff == exp_ff, 1'b1);
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The match count never passes the configured ceiling.
   assert property (@(posedge clock) disable iff (reset)
      found_ff <= 6'(MAX_EXPECTED))
      else $error("match count above ceiling");

   // The edge count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("edge count above table depth");

   // An entry under test always lies below the stored edge count.
   assert property (@(posedge clock) disable iff (reset)
      tv_ff |-> (tidx_ff < count_ff))
      else $error("scan tested an entry past the stored edges");

   // A matching-edge word is never the final word of its query.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && (res_ff.kind == KIND_MATCH)) |-> !res_ff.last)
      else $error("matching edge word marked last");

   // No table write happens while a scan is running.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !mem_ctl.wr_en)
      else $error("table written during a scan");

endmodule
